### design/lfu_pkg.sv
// Shared definitions for the LFU frame replacer: operation codes, field widths,
// register reset value and the compare-unit operation select.
// No dependencies.
`default_nettype none

package lfu_pkg;

  localparam int FRAME_W = 6;
  localparam int MODE_W = 2;
  localparam int CFG_W = 7;
  localparam int TCOUNT_W = 7;

  localparam int DEF_FRAMES = 64;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNPIN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  // compare unit operation
  typedef logic [0:0] cmp_op_t;
  localparam cmp_op_t CMP_MIN = 1'b0;   // (count, rank) of candidate below best
  localparam cmp_op_t CMP_DROP = 1'b1;  // reference rank below candidate rank

endpackage

`default_nettype wire

### design/lfu_cmp_unit.sv
// Shared magnitude compare used by both scan passes of the LFU replacer.
// Depends on lfu_pkg for the operation select codes.
`default_nettype none

module lfu_cmp_unit
  import lfu_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int RANK_BITS = 6
) (
  input  wire cmp_op_t               op,
  input  wire logic [COUNT_BITS-1:0] cand_cnt,
  input  wire logic [RANK_BITS-1:0]  cand_rank,
  input  wire logic [COUNT_BITS-1:0] best_cnt,
  input  wire logic [RANK_BITS-1:0]  best_rank,
  input  wire logic [RANK_BITS-1:0]  ref_rank,
  output logic                       less
);

  localparam int KEY_W = COUNT_BITS + RANK_BITS;

  logic [KEY_W-1:0] a_key;
  logic [KEY_W-1:0] b_key;

  always_comb begin
    unique case (op)
      CMP_MIN: begin
        a_key = {cand_cnt, cand_rank};
        b_key = {best_cnt, best_rank};
      end
      CMP_DROP: begin
        a_key = {{COUNT_BITS{1'b0}}, ref_rank};
        b_key = {{COUNT_BITS{1'b0}}, cand_rank};
      end
      default: begin
        a_key = '0;
        b_key = '0;
      end
    endcase
  end

  assign less = (a_key < b_key);

endmodule

`default_nettype wire

### design/lfu_frame_replacer_core.sv
// LFU frame replacer: sequencer, count/rank memories and valid bits.
// Depends on lfu_pkg and lfu_cmp_unit.
//
// Usage: one request on in_valid/in_ready carries mode and frame. Victim
// evicts the tracked frame with the lowest use count (earliest to reach
// that count on ties); pin stops tracking a frame; unpin bumps a tracked
// frame's count or adds a new one with count 1 while below capacity_limit.
// Each request yields one result on out_valid/out_ready: found,
// victim_frame and tracked_count.
// in_ready is high only while the sequencer is idle. A victim request with
// tracked frames takes two passes over the FRAMES memory entries (minimum
// search, then rank compaction); pin or unpin of a tracked frame takes one
// compaction pass; other requests take no pass. Each pass walks the single
// memory read port with the scan counter.
// The result sits in an output register; a new request is taken while it
// waits, and a finished result holds the sequencer until the slot frees.
// Synchronous reset clears all valid bits, the population count and
// restores capacity_limit to 64; no clearing pass is needed.
// cfg_wen/cfg_wdata write capacity_limit and must be used only when idle.
`default_nettype none

module lfu_frame_replacer_core
  import lfu_pkg::*;
#(
  parameter int FRAMES = DEF_FRAMES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [FRAME_W-1:0]  frame,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     found,
  output logic [FRAME_W-1:0]       victim_frame,
  output logic [TCOUNT_W-1:0]      tracked_count
);

  localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int CNT_W = IDX_BITS + 1;
  localparam int POP_BITS = $clog2(FRAMES + 1);
  localparam int RNG_W = ((FRAME_W > CNT_W) ? FRAME_W : CNT_W) + 1;
  localparam int CAPC_W = (POP_BITS > CFG_W) ? POP_BITS : CFG_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDF    = 3'd1;
  localparam logic [2:0] ST_GRAB   = 3'd2;
  localparam logic [2:0] ST_MIN    = 3'd3;
  localparam logic [2:0] ST_DROP   = 3'd4;
  localparam logic [2:0] ST_APPEND = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0] state;

  logic [CFG_W-1:0]    capacity_limit;
  logic [FRAMES-1:0]   tracked;
  logic [POP_BITS-1:0] population;

  logic [COUNT_BITS-1:0] cnt_mem [FRAMES];
  logic [RANK_BITS-1:0]  rank_mem [FRAMES];
  logic [COUNT_BITS-1:0] cnt_q;
  logic [RANK_BITS-1:0]  rank_q;

  logic [MODE_W-1:0]     op_mode;
  logic [IDX_BITS-1:0]   op_frame;
  logic [CNT_W-1:0]      idx;
  logic                  lag_valid;
  logic [IDX_BITS-1:0]   lag_idx;
  logic                  have;
  logic [IDX_BITS-1:0]   best_idx;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [RANK_BITS-1:0]  best_rank;
  logic [RANK_BITS-1:0]  drop_rank;
  logic [COUNT_BITS-1:0] append_cnt;
  logic                  res_found;
  logic [FRAME_W-1:0]    res_victim;

  logic                  in_fire;
  logic                  in_range;
  logic [IDX_BITS-1:0]   in_idx;
  logic                  room;
  logic                  issuing;
  logic                  scan_done;
  logic [IDX_BITS-1:0]   rd_addr;
  cmp_op_t               cmp_op;
  logic                  cmp_less;
  logic                  rank_we;
  logic [IDX_BITS-1:0]   rank_waddr;
  logic [RANK_BITS-1:0]  rank_wdata;

  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign in_range = (RNG_W'(frame) < RNG_W'(FRAMES));
  assign in_idx = IDX_BITS'(frame);
  assign room = (CAPC_W'(population) < CAPC_W'(capacity_limit));

  assign issuing = (idx < CNT_W'(FRAMES));
  assign scan_done = !issuing && !lag_valid;
  assign rd_addr = (state == ST_RDF) ? op_frame : idx[IDX_BITS-1:0];
  assign cmp_op = (state == ST_DROP) ? CMP_DROP : CMP_MIN;

  lfu_cmp_unit #(
    .COUNT_BITS(COUNT_BITS),
    .RANK_BITS (RANK_BITS)
  ) u_cmp (
    .op       (cmp_op),
    .cand_cnt (cnt_q),
    .cand_rank(rank_q),
    .best_cnt (best_cnt),
    .best_rank(best_rank),
    .ref_rank (drop_rank),
    .less     (cmp_less)
  );

  // rank memory write: compaction decrement or append at the newest rank
  always_comb begin
    rank_we = 1'b0;
    rank_waddr = lag_idx;
    rank_wdata = rank_q - RANK_BITS'(1);
    if (state == ST_DROP) begin
      rank_we = lag_valid && tracked[lag_idx] && cmp_less;
    end else if (state == ST_APPEND) begin
      rank_we = 1'b1;
      rank_waddr = op_frame;
      rank_wdata = RANK_BITS'(population);
    end
  end

  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
    if (state == ST_APPEND) begin
      cnt_mem[op_frame] <= append_cnt;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity_limit <= cfg_wdata;
    end
  end

  // scan pipeline: address idx now, data for lag_idx next cycle;
  // the counter rewinds at the end of each pass
  always_ff @(posedge clk) begin
    if ((state == ST_MIN || state == ST_DROP) && !scan_done) begin
      lag_valid <= issuing;
      lag_idx <= idx[IDX_BITS-1:0];
      if (issuing) begin
        idx <= idx + CNT_W'(1);
      end
    end else begin
      lag_valid <= 1'b0;
      idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tracked <= '0;
      population <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op_mode <= mode;
            op_frame <= in_idx;
            res_found <= 1'b0;
            res_victim <= '0;
            have <= 1'b0;
            append_cnt <= COUNT_BITS'(1);
            case (mode)
              MODE_VICTIM: begin
                state <= (population != '0) ? ST_MIN : ST_RESP;
              end
              MODE_PIN: begin
                state <= (in_range && tracked[in_idx]) ? ST_RDF : ST_RESP;
              end
              MODE_UNPIN: begin
                if (in_range && tracked[in_idx]) begin
                  state <= ST_RDF;
                end else if (in_range && room) begin
                  state <= ST_APPEND;
                end else begin
                  state <= ST_RESP;
                end
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_RDF: begin
          state <= ST_GRAB;
        end
        ST_GRAB: begin
          drop_rank <= rank_q;
          append_cnt <= (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + COUNT_BITS'(1);
          tracked[op_frame] <= 1'b0;
          population <= population - POP_BITS'(1);
          state <= ST_DROP;
        end
        ST_MIN: begin
          if (lag_valid && tracked[lag_idx] && (!have || cmp_less)) begin
            have <= 1'b1;
            best_idx <= lag_idx;
            best_cnt <= cnt_q;
            best_rank <= rank_q;
          end
          if (scan_done) begin
            drop_rank <= best_rank;
            tracked[best_idx] <= 1'b0;
            population <= population - POP_BITS'(1);
            res_found <= 1'b1;
            res_victim <= FRAME_W'(best_idx);
            state <= ST_DROP;
          end
        end
        ST_DROP: begin
          if (scan_done) begin
            state <= (op_mode == MODE_UNPIN) ? ST_APPEND : ST_RESP;
          end
        end
        ST_APPEND: begin
          tracked[op_frame] <= 1'b1;
          population <= population + POP_BITS'(1);
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid || out_ready) begin
            found <= res_found;
            victim_frame <= res_victim;
            tracked_count <= TCOUNT_W'(population);
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
